FILE: design/sfd_pkg.sv
// sfd_pkg: shared types and constants of the serial frame decoder
// no dependencies; used by sfd_in_stage, sfd_core and serial_frame_decoder
`default_nettype none

package sfd_pkg;

   // frame marker bytes and checksum bias
   localparam logic [7:0] MARK0      = 8'h4C;
   localparam logic [7:0] MARK1      = 8'h4D;
   localparam logic [7:0] MARK2      = 8'h58;
   localparam logic [7:0] CHECK_BIAS = 8'h01;

   // max_payload value after reset
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1024;

   // input operation codes
   typedef enum logic [0:0] {
      FUNC_RECEIVE = 1'b0,
      FUNC_RESYNC  = 1'b1
   } func_type;

   // receive phases, one-hot
   typedef enum logic [8:0] {
      PH_HUNT   = 9'b000000001,
      PH_M      = 9'b000000010,
      PH_X      = 9'b000000100,
      PH_VERIFY = 9'b000001000,
      PH_LEN0   = 9'b000010000,
      PH_LEN1   = 9'b000100000,
      PH_LEN2   = 9'b001000000,
      PH_LEN3   = 9'b010000000,
      PH_DATA   = 9'b100000000
   } phase_type;

   // one input item
   typedef struct packed {
      func_type   func;
      logic [7:0] rx_byte;
   } item_type;

   // one result item
   typedef struct packed {
      logic        header_found;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic        frame_done;
      logic        frame_ok;
      logic [31:0] frame_length;
   } result_type;

endpackage

`default_nettype wire

FILE: design/sfd_in_stage.sv
// sfd_in_stage: input register of the serial frame decoder
// depends on sfd_pkg for the item type
`default_nettype none

module sfd_in_stage (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  sfd_pkg::item_type   in_item,
   output logic                out_valid,
   input  wire                 out_ready,
   output sfd_pkg::item_type   out_item
);

   logic              valid_ff;
   logic              valid_in;
   sfd_pkg::item_type item_ff;

   // stage is free when empty or draining this cycle
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture on transfer
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

FILE: design/sfd_core.sv
// sfd_core: frame state machine, running sum and result register
// depends on sfd_pkg for types, phase codes and marker constants
`default_nettype none

module sfd_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [31:0]          max_payload,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  sfd_pkg::item_type    in_item,
   output logic                 out_valid,
   input  wire                  out_ready,
   output sfd_pkg::result_type  out_result
);

   sfd_pkg::phase_type  phase_ff,  phase_in;
   logic [7:0]          check_ff,  check_in;
   logic [31:0]         length_ff, length_in;
   logic [31:0]         remain_ff, remain_in;
   logic [7:0]          sum_ff,    sum_in;
   logic                valid_ff,  valid_in;
   sfd_pkg::result_type result_ff, result_in;

   logic        fire;
   logic [7:0]  b;
   logic [31:0] len_full;
   logic        take_byte;
   logic [7:0]  sum_next;

   assign in_ready = !valid_ff || out_ready;
   assign fire     = in_valid && in_ready;
   assign b        = in_item.rx_byte;

   // length with the last header byte merged in
   assign len_full  = length_ff | {b, 24'd0};
   // payload bytes still owed in the data phase
   assign take_byte = (remain_ff != 32'd0);
   assign sum_next  = take_byte ? sum_ff + b : sum_ff;

   // next state and result for one item
   always_comb begin
      phase_in  = phase_ff;
      check_in  = check_ff;
      length_in = length_ff;
      remain_in = remain_ff;
      sum_in    = sum_ff;
      result_in = '0;
      if (in_item.func == sfd_pkg::FUNC_RESYNC) begin
         phase_in  = sfd_pkg::PH_HUNT;
         remain_in = 32'd0;
      end else begin
         unique case (phase_ff)
            sfd_pkg::PH_HUNT: begin
               length_in = 32'd0;
               sum_in    = 8'd0;
               remain_in = 32'd0;
               phase_in  = (b == sfd_pkg::MARK0) ? sfd_pkg::PH_M : sfd_pkg::PH_HUNT;
            end
            sfd_pkg::PH_M: begin
               phase_in = (b == sfd_pkg::MARK1) ? sfd_pkg::PH_X : sfd_pkg::PH_HUNT;
            end
            sfd_pkg::PH_X: begin
               phase_in = (b == sfd_pkg::MARK2) ? sfd_pkg::PH_VERIFY : sfd_pkg::PH_HUNT;
            end
            sfd_pkg::PH_VERIFY: begin
               check_in = b;
               phase_in = sfd_pkg::PH_LEN0;
            end
            sfd_pkg::PH_LEN0: begin
               length_in = length_ff | {24'd0, b};
               phase_in  = sfd_pkg::PH_LEN1;
            end
            sfd_pkg::PH_LEN1: begin
               length_in = length_ff | {16'd0, b, 8'd0};
               phase_in  = sfd_pkg::PH_LEN2;
            end
            sfd_pkg::PH_LEN2: begin
               length_in = length_ff | {8'd0, b, 16'd0};
               phase_in  = sfd_pkg::PH_LEN3;
            end
            sfd_pkg::PH_LEN3: begin
               length_in = len_full;
               if (len_full > max_payload) begin
                  // oversized frame is dropped
                  phase_in = sfd_pkg::PH_HUNT;
               end else begin
                  phase_in               = sfd_pkg::PH_DATA;
                  remain_in              = len_full;
                  sum_in                 = 8'd0;
                  result_in.header_found = 1'b1;
                  result_in.frame_length = len_full;
               end
            end
            sfd_pkg::PH_DATA: begin
               sum_in = sum_next;
               if (take_byte) begin
                  result_in.data_valid = 1'b1;
                  result_in.data_byte  = b;
                  remain_in            = remain_ff - 32'd1;
               end
               // last payload byte, or the byte after a zero-length header
               if (!take_byte || remain_ff == 32'd1) begin
                  result_in.frame_done   = 1'b1;
                  result_in.frame_ok     = ((sum_next + sfd_pkg::CHECK_BIAS
                                             + sfd_pkg::MARK2) == check_ff);
                  result_in.frame_length = length_ff;
                  phase_in               = sfd_pkg::PH_HUNT;
                  remain_in              = 32'd0;
               end
            end
            default: begin
               phase_in = sfd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // result handshake
   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sfd_pkg::PH_HUNT;
         check_ff  <= 8'd0;
         length_ff <= 32'd0;
         remain_ff <= 32'd0;
         sum_ff    <= 8'd0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            phase_ff  <= phase_in;
            check_ff  <= check_in;
            length_ff <= length_in;
            remain_ff <= remain_in;
            sum_ff    <= sum_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

FILE: design/serial_frame_decoder.sv
// an input transfer passes the input register and then the result register before its result is presented
// throughput: one byte per cycle while the result stream is not stalled; the frame state updates once per byte
// reset: synchronous, active high; hunt for the marker, sums and counts cleared,
// max_payload returns to 1024; the csr port takes a write in any cycle
// serial_frame_decoder: top level; depends on sfd_pkg, sfd_in_stage and sfd_core
`default_nettype none

module serial_frame_decoder (
   input  wire         clock,
   input  wire         reset,
   // input byte stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire  [0:0]  req_tuser,   // [0] func
   // result stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] data_byte, [8] frame_ok, [40:9] frame_length
   output logic [2:0]  rsp_tuser,   // [0] header_found, [1] data_valid, [2] frame_done
   // max_payload register write
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [31:0] csr_data
);

   logic [31:0]         max_payload_ff;
   sfd_pkg::item_type   req_item;
   sfd_pkg::item_type   s1_item;
   logic                s1_valid;
   logic                s1_ready;
   sfd_pkg::result_type result;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= sfd_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         max_payload_ff <= csr_data;
      end
   end

   // unpack the input transfer
   always_comb begin
      req_item.func    = sfd_pkg::func_type'(req_tuser[0]);
      req_item.rx_byte = req_tdata;
   end

   sfd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_item  (s1_item)
   );

   sfd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .max_payload (max_payload_ff),
      .in_valid    (s1_valid),
      .in_ready    (s1_ready),
      .in_item     (s1_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   // pack the result transfer
   assign rsp_tdata = {7'd0, result.frame_length, result.frame_ok, result.data_byte};
   assign rsp_tuser = {result.frame_done, result.data_valid, result.header_found};

endmodule

`default_nettype wire

FILE: verif/serial_frame_decoder_tb.sv
// serial_frame_decoder_tb: self-checking testbench for the serial frame decoder
// drives a directed table and then random frames, and checks every result against its
// own decode model or the table's typed result; depends on sfd_pkg and serial_frame_decoder
`default_nettype none

module serial_frame_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT        = 2000;
   localparam int DIR_ROWS              = 30;
   localparam int PHASE_ITEMS           = 137;
   localparam sfd_pkg::result_type ZERO = '0;

   typedef struct {
      sfd_pkg::func_type   fn;
      logic [7:0]          b;
      bit                  typed;
      sfd_pkg::result_type res;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] rx_byte
   logic [0:0]  req_tuser = '0;   // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [7:0] data_byte, [8] frame_ok, [40:9] frame_length
   logic [2:0]  rsp_tuser;        // [0] header_found, [1] data_valid, [2] frame_done
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // decode model state
   sfd_pkg::phase_type dec_phase   = sfd_pkg::PH_HUNT;
   logic [7:0]         verify_byte = '0;
   logic [31:0]        frame_len   = '0;
   logic [31:0]        byte_count  = '0;
   logic [7:0]         payload_sum = '0;
   logic [31:0]        max_len     = sfd_pkg::MAX_PAYLOAD_RESET;

   sfd_pkg::result_type pending_decodes[$];
   dir_row_type         dir_rows[DIR_ROWS];
   int                  fail_count   = 0;
   int                  items_sent   = 0;
   int                  quiet_cycles = 0;
   int                  stall_left   = 0;
   bit                  idling_on    = 1'b1;

   serial_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // advance the decode model by one byte and return the result it gives
   function automatic sfd_pkg::result_type decode_byte(input sfd_pkg::func_type fn,
                                                       input logic [7:0] b);
      sfd_pkg::result_type r;
      r = '0;
      if (fn == sfd_pkg::FUNC_RESYNC) begin
         dec_phase  = sfd_pkg::PH_HUNT;
         byte_count = '0;
      end else begin
         case (dec_phase)
            sfd_pkg::PH_DATA: begin
               if (byte_count < frame_len) begin
                  r.data_valid = 1'b1;
                  r.data_byte  = b;
                  payload_sum  = payload_sum + b;
                  byte_count   = byte_count + 1;
               end
               // last payload byte, or the byte after a zero-length header
               if (byte_count >= frame_len) begin
                  r.frame_done   = 1'b1;
                  r.frame_ok     = ((payload_sum + sfd_pkg::CHECK_BIAS + sfd_pkg::MARK2)
                                    & 8'hFF) == verify_byte;
                  r.frame_length = frame_len;
                  dec_phase      = sfd_pkg::PH_HUNT;
                  byte_count     = '0;
               end
            end
            sfd_pkg::PH_M:
               dec_phase = (b == sfd_pkg::MARK1) ? sfd_pkg::PH_X : sfd_pkg::PH_HUNT;
            sfd_pkg::PH_X:
               dec_phase = (b == sfd_pkg::MARK2) ? sfd_pkg::PH_VERIFY : sfd_pkg::PH_HUNT;
            sfd_pkg::PH_VERIFY: begin
               verify_byte = b;
               dec_phase   = sfd_pkg::PH_LEN0;
            end
            sfd_pkg::PH_LEN0: begin
               frame_len = frame_len | {24'd0, b};
               dec_phase = sfd_pkg::PH_LEN1;
            end
            sfd_pkg::PH_LEN1: begin
               frame_len = frame_len | ({24'd0, b} << 8);
               dec_phase = sfd_pkg::PH_LEN2;
            end
            sfd_pkg::PH_LEN2: begin
               frame_len = frame_len | ({24'd0, b} << 16);
               dec_phase = sfd_pkg::PH_LEN3;
            end
            sfd_pkg::PH_LEN3: begin
               frame_len = frame_len | ({24'd0, b} << 24);
               // oversized frames are dropped without a header report
               if (frame_len > max_len) begin
                  dec_phase = sfd_pkg::PH_HUNT;
               end else begin
                  dec_phase      = sfd_pkg::PH_DATA;
                  byte_count     = '0;
                  payload_sum    = '0;
                  r.header_found = 1'b1;
                  r.frame_length = frame_len;
               end
            end
            default: begin
               byte_count  = '0;
               frame_len   = '0;
               payload_sum = '0;
               dec_phase   = (b == sfd_pkg::MARK0) ? sfd_pkg::PH_M : sfd_pkg::PH_HUNT;
            end
         endcase
      end
      return r;
   endfunction

   function automatic sfd_pkg::item_type rx(input logic [7:0] b);
      sfd_pkg::item_type it;
      it.func    = sfd_pkg::FUNC_RECEIVE;
      it.rx_byte = b;
      return it;
   endfunction

   // one input transfer, with an optional idle burst ahead of it
   task automatic send_item(input sfd_pkg::func_type fn, input logic [7:0] b,
                            input bit typed, input sfd_pkg::result_type typed_res);
      sfd_pkg::result_type pred;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = decode_byte(fn, b);
      pending_decodes.push_back(typed ? typed_res : pred);
      items_sent++;
   endtask

   // stop sending and let every outstanding result drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max(input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      max_len = v;
   endtask

   // one random burst: good frames, broken frames, huge lengths or noise
   task automatic send_frame_burst();
      sfd_pkg::item_type seq[$];
      logic [31:0]       len;
      logic [7:0]        sum;
      logic [7:0]        pay;
      int                kind;
      int                cut;
      int                n;
      kind = $urandom_range(0, 99);
      sum  = '0;
      if (kind < 60 || (kind >= 80 && kind < 90)) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
         if (len > max_len) len = max_len;
         seq.push_back(rx(sfd_pkg::MARK0));
         seq.push_back(rx(sfd_pkg::MARK1));
         seq.push_back(rx(sfd_pkg::MARK2));
         seq.push_back(rx(8'h00));
         seq.push_back(rx(len[7:0]));
         seq.push_back(rx(len[15:8]));
         seq.push_back(rx(len[23:16]));
         seq.push_back(rx(len[31:24]));
         for (int i = 0; i < int'(len); i++) begin
            pay = 8'($urandom_range(0, 255));
            sum = sum + pay;
            seq.push_back(rx(pay));
         end
         // a zero-length frame completes on one discarded byte
         if (len == 0) seq.push_back(rx(8'($urandom_range(0, 255))));
         // mostly a matching checksum, sometimes a random one
         seq[3].rx_byte = ($urandom_range(0, 3) != 0)
                          ? sum + sfd_pkg::CHECK_BIAS + sfd_pkg::MARK2
                          : 8'($urandom_range(0, 255));
         if (kind >= 80) begin
            cut = $urandom_range(0, seq.size() - 1);
            seq[cut].func = sfd_pkg::FUNC_RESYNC;
         end
      end else if (kind < 70) begin
         len = $urandom;
         seq.push_back(rx(sfd_pkg::MARK0));
         seq.push_back(rx(sfd_pkg::MARK1));
         seq.push_back(rx(sfd_pkg::MARK2));
         seq.push_back(rx(8'($urandom_range(0, 255))));
         seq.push_back(rx(len[7:0]));
         seq.push_back(rx(len[15:8]));
         seq.push_back(rx(len[23:16]));
         seq.push_back(rx(len[31:24]));
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) seq.push_back(rx(8'($urandom_range(0, 255))));
         seq.push_back(rx(8'($urandom_range(0, 255))));
         seq[seq.size() - 1].func = sfd_pkg::FUNC_RESYNC;
      end else if (kind < 80) begin
         // marker broken at the second or third byte
         seq.push_back(rx(sfd_pkg::MARK0));
         if ($urandom_range(0, 1) == 0) begin
            seq.push_back(rx(($urandom_range(0, 1) == 0) ? sfd_pkg::MARK0
                                                         : 8'($urandom_range(0, 255))));
         end else begin
            seq.push_back(rx(sfd_pkg::MARK1));
            seq.push_back(rx(($urandom_range(0, 1) == 0) ? sfd_pkg::MARK0
                                                         : 8'($urandom_range(0, 255))));
         end
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            seq.push_back(rx(($urandom_range(0, 3) == 0) ? sfd_pkg::MARK0
                                                         : 8'($urandom_range(0, 255))));
            if ($urandom_range(0, 3) == 0) seq[i].func = sfd_pkg::FUNC_RESYNC;
         end
      end
      foreach (seq[i]) send_item(seq[i].func, seq[i].rx_byte, 1'b0, ZERO);
   endtask

   // compare one result transfer with the oldest expected decode
   task automatic check_result();
      sfd_pkg::result_type got;
      sfd_pkg::result_type want;
      got.header_found = rsp_tuser[0];
      got.data_valid   = rsp_tuser[1];
      got.frame_done   = rsp_tuser[2];
      got.data_byte    = rsp_tdata[7:0];
      got.frame_ok     = rsp_tdata[8];
      got.frame_length = rsp_tdata[40:9];
      if (pending_decodes.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("result with nothing expected at %0t", $realtime);
      end else begin
         want = pending_decodes.pop_front();
         if (got.header_found !== want.header_found || got.data_valid !== want.data_valid ||
             got.data_byte !== want.data_byte || got.frame_done !== want.frame_done ||
             got.frame_ok !== want.frame_ok || got.frame_length !== want.frame_length) begin
            fail_count++;
            // fields: header_found data_valid data_byte frame_done frame_ok frame_length
            if (fail_count <= 10)
               $display("mismatch at %0t: exp %b %b %h %b %b %0d, got %b %b %h %b %b %0d",
                        $realtime, want.header_found, want.data_valid, want.data_byte,
                        want.frame_done, want.frame_ok, want.frame_length,
                        got.header_found, got.data_valid, got.data_byte,
                        got.frame_done, got.frame_ok, got.frame_length);
         end
      end
   endtask

   // result side: check each transfer, stall in random bursts
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) check_result();
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [31:0] settings[6];
      int          target;

      // directed table: marker mismatch, zero length, full byte, bad checksum,
      // all-ones oversized length, resync
      dir_rows = '{
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK0, 1'b1, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK0, 1'b1, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK1, 1'b1, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK0, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK1, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK2, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h59, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h00, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h00, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h00, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h00, 1'b1,
           sfd_pkg::result_type'({1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0})},
         '{sfd_pkg::FUNC_RECEIVE, 8'hFF, 1'b1,
           sfd_pkg::result_type'({1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 32'd0})},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK0, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK1, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK2, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h00, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h01, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h00, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h00, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'h00, 1'b1,
           sfd_pkg::result_type'({1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'd1})},
         '{sfd_pkg::FUNC_RECEIVE, 8'hFF, 1'b1,
           sfd_pkg::result_type'({1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 32'd1})},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK0, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK1, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, sfd_pkg::MARK2, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'hFF, 1'b0, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'hFF, 1'b1, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'hFF, 1'b1, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'hFF, 1'b1, ZERO},
         '{sfd_pkg::FUNC_RECEIVE, 8'hFF, 1'b1, ZERO},
         '{sfd_pkg::FUNC_RESYNC,  8'hFF, 1'b1, ZERO}
      };

      settings[0] = 32'hFFFF_FFFF;
      settings[1] = 32'd0;
      settings[2] = 32'd1;
      settings[3] = $urandom_range(2, 64);
      settings[4] = sfd_pkg::MAX_PAYLOAD_RESET;
      settings[5] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_item(dir_rows[i].fn, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
      settle();

      // random frames under each max_payload setting, no idling in the last one
      for (int p = 0; p < 6; p++) begin
         if (p == 5) idling_on = 1'b0;
         write_max(settings[p]);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_frame_burst();
         settle();
      end

      repeat (8) @(posedge clock);
      fail_count += pending_decodes.size();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
